@@ rtl/lfr_pkg.sv @@
// ----------------------------------------------------------------------------
// lfr_pkg: shared types and constants of the LRU frame replacer
// Frame list size, command codes and the request and response beat layouts.
// ----------------------------------------------------------------------------
package lfr_pkg;

    // list geometry
    localparam int NUM_FRAMES = 64;
    localparam int FRAME_W    = 6;
    localparam int COUNT_W    = $clog2(NUM_FRAMES + 1);
    localparam int CAP_W      = 7;

    // command codes
    localparam logic [1:0] CMD_VICTIM = 2'd0;
    localparam logic [1:0] CMD_PIN    = 2'd1;
    localparam logic [1:0] CMD_UNPIN  = 2'd2;

    // request beat
    typedef struct packed {
        logic [1:0]         cmd;
        logic [FRAME_W-1:0] frame;
    } lfr_req_t;

    // response beat
    typedef struct packed {
        logic               victim_found;
        logic [FRAME_W-1:0] victim_frame;
        logic [COUNT_W-1:0] entry_count;
    } lfr_rsp_t;

    // registered command handed to the list
    typedef struct packed {
        logic     valid;
        lfr_req_t req;
    } lfr_op_t;

endpackage

@@ rtl/lfr_list.sv @@
// ----------------------------------------------------------------------------
// lfr_list: ordered frame list with parallel match
// Slot 0 holds the oldest frame; every slot compares against the command
// frame at once, and the list updates once per valid command.
// ----------------------------------------------------------------------------
module lfr_list (
    input  logic                     clk,
    input  logic                     rst_n,
    input  lfr_pkg::lfr_op_t         op,
    input  logic [lfr_pkg::CAP_W-1:0] capacity,
    output lfr_pkg::lfr_rsp_t        rsp
);
    import lfr_pkg::*;

    logic [FRAME_W-1:0]    slots_reg  [NUM_FRAMES];
    logic [FRAME_W-1:0]    slots_next [NUM_FRAMES];
    logic [NUM_FRAMES-1:0] listed_reg;
    logic [NUM_FRAMES-1:0] listed_next;
    logic [COUNT_W-1:0]    len_reg;
    logic [COUNT_W-1:0]    len_next;

    logic [NUM_FRAMES-1:0] match;
    logic [NUM_FRAMES-1:0] at_or_above;
    logic [COUNT_W-1:0]    eff_cap;
    logic                  is_listed;
    logic                  has_room;
    logic                  found;
    logic [FRAME_W-1:0]    vframe;

    // match of the command frame against the occupied slots
    always_comb
    begin
        for (int i = 0; i < NUM_FRAMES; i++)
        begin
            match[i] = (COUNT_W'(i) < len_reg) && (slots_reg[i] == op.req.frame);
        end
        // frames are unique, so match is one-hot or zero; this marks pos and above
        at_or_above = ~(match - NUM_FRAMES'(1));
    end

    // capacity saturates at the list size
    always_comb
    begin
        if (capacity > CAP_W'(NUM_FRAMES))
        begin
            eff_cap = COUNT_W'(NUM_FRAMES);
        end
        else
        begin
            eff_cap = COUNT_W'(capacity);
        end
        is_listed = listed_reg[op.req.frame];
        has_room  = (len_reg < eff_cap) && (len_reg < COUNT_W'(NUM_FRAMES));
    end

    // next list state for the current command
    always_comb
    begin
        slots_next  = slots_reg;
        listed_next = listed_reg;
        len_next    = len_reg;
        found       = 1'b0;
        vframe      = '0;
        case (op.req.cmd)
            CMD_VICTIM:
            begin
                if (len_reg != '0)
                begin
                    found  = 1'b1;
                    vframe = slots_reg[0];
                    for (int i = 0; i < NUM_FRAMES - 1; i++)
                    begin
                        slots_next[i] = slots_reg[i+1];
                    end
                    listed_next[slots_reg[0]] = 1'b0;
                    len_next = len_reg - COUNT_W'(1);
                end
            end
            CMD_PIN:
            begin
                if (is_listed)
                begin
                    // close the gap above the pinned frame
                    for (int i = 0; i < NUM_FRAMES - 1; i++)
                    begin
                        if (at_or_above[i])
                        begin
                            slots_next[i] = slots_reg[i+1];
                        end
                    end
                    listed_next[op.req.frame] = 1'b0;
                    len_next = len_reg - COUNT_W'(1);
                end
            end
            CMD_UNPIN:
            begin
                if (!is_listed && has_room)
                begin
                    // newest frame goes just above the current top
                    for (int i = 0; i < NUM_FRAMES; i++)
                    begin
                        if (COUNT_W'(i) == len_reg)
                        begin
                            slots_next[i] = op.req.frame;
                        end
                    end
                    listed_next[op.req.frame] = 1'b1;
                    len_next = len_reg + COUNT_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign rsp.victim_found = found;
    assign rsp.victim_frame = vframe;
    assign rsp.entry_count  = len_next;

    // slot contents, no reset
    always_ff @(posedge clk)
    begin
        if (op.valid)
        begin
            slots_reg <= slots_next;
        end
    end

    // listed flags and length
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            listed_reg <= '0;
            len_reg    <= '0;
        end
        else if (op.valid)
        begin
            listed_reg <= listed_next;
            len_reg    <= len_next;
        end
    end

    // length never exceeds the list size
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= COUNT_W'(NUM_FRAMES))
        else $error("list length above list size");

    // flags and length stay consistent
    a_flags_len: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(listed_reg) == int'(len_reg))
        else $error("listed flag count differs from list length");

    // a found victim shortens the list by one
    a_victim_len: assert property (@(posedge clk) disable iff (!rst_n)
        (op.valid && found) |=> (len_reg == $past(len_reg) - COUNT_W'(1)))
        else $error("victim did not shorten the list");

    // a listed frame is always found among the occupied slots
    a_pin_match: assert property (@(posedge clk) disable iff (!rst_n)
        (op.valid && (op.req.cmd == CMD_PIN) && is_listed) |-> $onehot(match))
        else $error("listed frame missing from slots");

endmodule

@@ rtl/lru_frame_replacer.sv @@
// ----------------------------------------------------------------------------
// lru_frame_replacer: least recently unpinned frame replacer
// Commands victim, pin and unpin run against an ordered list of frames.
// ----------------------------------------------------------------------------
// Usage
//   Command channel: a request beat (cmd, frame) is taken at a rising edge
//   with start high and busy low. Every command returns one response beat
//   (victim_found, victim_frame, entry_count) on rsp with done high for
//   exactly one cycle; the receiver takes it at that edge and cannot stall.
//   Response path: the command beat is held in the input register, then the
//   list update is written into the result register, and done rises with
//   the response beat.
//   Throughput: one command per cycle while busy is low; the whole list,
//   with its parallel frame match and shift, updates in the cycle after
//   the input register.
//   Configuration: cfg_data carries capacity, written when cfg_valid and
//   cfg_ready are high; cfg_ready is always high. Write only while idle.
//   Reset: the list is empty, capacity is 64, and busy stays high for the
//   first cycle after reset is released.
// ----------------------------------------------------------------------------
module lru_frame_replacer (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  lfr_pkg::lfr_req_t         req,
    output logic                      done,
    output lfr_pkg::lfr_rsp_t         rsp,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [lfr_pkg::CAP_W-1:0] cfg_data
);
    import lfr_pkg::*;

    logic               busy_reg;
    logic               in_valid_reg;
    lfr_req_t           in_req_reg;
    logic [CAP_W-1:0]   capacity_reg;
    logic               done_reg;
    lfr_rsp_t           rsp_reg;
    lfr_op_t            op;
    lfr_rsp_t           list_rsp;
    logic               accept;

    assign accept    = start && !busy_reg;
    assign busy      = busy_reg;
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign rsp       = rsp_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b1;
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
            capacity_reg <= CAP_W'(64);
        end
        else
        begin
            busy_reg     <= 1'b0;
            in_valid_reg <= accept;
            done_reg     <= in_valid_reg;
            if (cfg_valid && cfg_ready)
            begin
                capacity_reg <= cfg_data;
            end
        end
    end

    // request and response beats
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_req_reg <= req;
        end
        if (in_valid_reg)
        begin
            rsp_reg <= list_rsp;
        end
    end

    assign op.valid = in_valid_reg;
    assign op.req   = in_req_reg;

    lfr_list u_list (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (op),
        .capacity (capacity_reg),
        .rsp      (list_rsp)
    );

endmodule

@@ sim/lfr_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lfr_checker: response checker for the LRU frame replacer
// Watches the command, response and configuration channels, keeps its own
// copy of the frame list, and compares every response beat field by field.
// ----------------------------------------------------------------------------
module lfr_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      busy,
    input  lfr_pkg::lfr_req_t         req,
    input  logic                      done,
    input  lfr_pkg::lfr_rsp_t         rsp,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [lfr_pkg::CAP_W-1:0] cfg_data,
    output int                        errors,
    output logic                      idle
);
    import lfr_pkg::*;

    // shadow list, newest frame in slot 0
    logic [FRAME_W-1:0] frame_order [NUM_FRAMES];
    bit                 frame_listed [NUM_FRAMES];
    int unsigned        list_len;
    logic [CAP_W-1:0]   capacity_r;

    // responses owed by the block, oldest first
    lfr_rsp_t owed_rsp [$];

    // apply one command to the shadow list and return its response
    function automatic lfr_rsp_t list_update(lfr_req_t r);
        lfr_rsp_t    res;
        int unsigned pos;
        int unsigned lim;
        res = '0;
        lim = (capacity_r < NUM_FRAMES) ? capacity_r : NUM_FRAMES;
        case (r.cmd)
            CMD_VICTIM:
            begin
                if (list_len > 0)
                begin
                    res.victim_found = 1'b1;
                    res.victim_frame = frame_order[list_len-1];
                    frame_listed[frame_order[list_len-1]] = 1'b0;
                    list_len--;
                end
            end
            CMD_PIN:
            begin
                if (frame_listed[r.frame])
                begin
                    pos = list_len;
                    for (int i = list_len - 1; i >= 0; i--)
                        if (frame_order[i] == r.frame)
                            pos = i;
                    // close the gap left by the pinned frame
                    for (int unsigned i = pos; i + 1 < list_len; i++)
                        frame_order[i] = frame_order[i+1];
                    list_len--;
                    frame_listed[r.frame] = 1'b0;
                end
            end
            CMD_UNPIN:
            begin
                if (!frame_listed[r.frame] && list_len < lim)
                begin
                    for (int unsigned i = list_len; i > 0; i--)
                        frame_order[i] = frame_order[i-1];
                    frame_order[0] = r.frame;
                    list_len++;
                    frame_listed[r.frame] = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        res.entry_count = list_len[COUNT_W-1:0];
        return res;
    endfunction

    // one line per mismatching field
    task automatic report(string field, int got, int want);
        $display("[%0t] %s: got %0d, expected %0d", $time, field, got, want);
        errors++;
    endtask

    // watch the channels
    always @(posedge clk or negedge rst_n)
    begin
        lfr_rsp_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_FRAMES; i++)
            begin
                frame_order[i]  = '0;
                frame_listed[i] = 1'b0;
            end
            list_len   = 0;
            capacity_r = 7'd64;
            owed_rsp.delete();
            errors     = 0;
            idle <= 1'b1;
        end
        else
        begin
            // response beat against the oldest owed response
            if (done)
            begin
                if (owed_rsp.size() == 0)
                    report("unexpected response beat", 1, 0);
                else
                begin
                    want = owed_rsp.pop_front();
                    if (rsp.victim_found !== want.victim_found)
                        report("victim_found", int'(rsp.victim_found),
                               int'(want.victim_found));
                    if (rsp.victim_frame !== want.victim_frame)
                        report("victim_frame", int'(rsp.victim_frame),
                               int'(want.victim_frame));
                    if (rsp.entry_count !== want.entry_count)
                        report("entry_count", int'(rsp.entry_count),
                               int'(want.entry_count));
                end
            end
            // capacity write beat
            if (cfg_valid && cfg_ready)
                capacity_r = cfg_data;
            // accepted command beat
            if (start && !busy)
                owed_rsp.push_back(list_update(req));
            idle <= (owed_rsp.size() == 0);
        end
    end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench top of the LRU frame replacer
// Drives directed and random victim, pin and unpin commands under several
// capacity settings with random gaps; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb;
    import lfr_pkg::*;

    localparam logic [1:0] CMD_NOP   = 2'd3;
    localparam int         MAX_CYCLE = 200000;
    localparam int         SETTLE    = 4;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    lfr_req_t         req;
    logic             done;
    lfr_rsp_t         rsp;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CAP_W-1:0] cfg_data;
    int               errors;
    logic             chk_idle;
    int               cycles;
    bit               no_gaps;

    lru_frame_replacer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    lfr_checker chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .idle      (chk_idle)
    );

    // clock
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > MAX_CYCLE)
        begin
            $display("lru_frame_replacer: mismatch");
            $finish;
        end
    end

    // one command beat, then maybe a random gap
    task automatic issue(logic [1:0] cmd, logic [FRAME_W-1:0] frame);
        start     <= 1'b1;
        req.cmd   <= cmd;
        req.frame <= frame;
        do @(posedge clk); while (busy);
        if (!no_gaps && $urandom_range(0, 99) < 24)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    // drain all owed responses and let the pipeline empty
    task automatic settle();
        start <= 1'b0;
        do @(posedge clk); while (!chk_idle);
        repeat (SETTLE) @(posedge clk);
    endtask

    // capacity write beat, only while idle
    task automatic set_capacity(logic [CAP_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // random phase of well-formed traffic with a little noise
    task automatic random_phase(int items, int unpin_w, int span);
        int                 r;
        logic [FRAME_W-1:0] base;
        logic [FRAME_W-1:0] frame;
        base = FRAME_W'($urandom_range(0, 63));
        for (int n = 0; n < items; n++)
        begin
            r     = $urandom_range(0, 99);
            frame = FRAME_W'(base + FRAME_W'($urandom_range(0, span)));
            if (r < unpin_w)
                issue(CMD_UNPIN, frame);
            else if (r < unpin_w + (95 - unpin_w) / 2)
                issue(CMD_PIN, frame);
            else if (r < 95)
                issue(CMD_VICTIM, FRAME_W'($urandom_range(0, 63)));
            else
                issue(CMD_NOP, frame);
        end
    endtask

    initial
    begin
        logic [CAP_W-1:0] cap;
        start     = 1'b0;
        req       = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        no_gaps   = 1'b0;
        rst_n     = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // small list: empty victim, refused pin, full list, relisting
        set_capacity(7'd2);
        issue(CMD_VICTIM, 6'd0);
        issue(CMD_PIN, 6'd5);
        issue(CMD_UNPIN, 6'd0);
        issue(CMD_UNPIN, 6'h3F);
        issue(CMD_UNPIN, 6'd7);
        issue(CMD_UNPIN, 6'd0);
        issue(CMD_NOP, 6'h3F);
        issue(CMD_VICTIM, 6'h3F);
        issue(CMD_VICTIM, 6'd0);
        issue(CMD_VICTIM, 6'd0);
        settle();

        // saturated capacity: pin from the middle, oldest and newest
        set_capacity(7'd127);
        issue(CMD_UNPIN, 6'd0);
        issue(CMD_UNPIN, 6'h3F);
        issue(CMD_UNPIN, 6'd21);
        issue(CMD_UNPIN, 6'd42);
        issue(CMD_UNPIN, 6'd0);
        issue(CMD_PIN, 6'd21);
        issue(CMD_PIN, 6'd0);
        issue(CMD_PIN, 6'd42);
        issue(CMD_NOP, 6'd0);
        issue(CMD_VICTIM, 6'd0);
        settle();

        // zero capacity refuses every unpin
        set_capacity(7'd0);
        issue(CMD_UNPIN, 6'd3);
        issue(CMD_UNPIN, 6'h2A);
        issue(CMD_VICTIM, 6'd0);
        settle();

        // random phases; the first fills the list, later ones vary the capacity
        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0: cap = 7'd127;
                1: cap = 7'd64;
                2: cap = 7'd5;
                3: cap = 7'd1;
                4: cap = 7'd0;
                5: cap = CAP_W'($urandom_range(0, 127));
                6: cap = 7'd2;
                default: cap = 7'd64;
            endcase
            set_capacity(cap);
            no_gaps = (p == 1);
            random_phase(150, (p == 0) ? 85 : $urandom_range(40, 85),
                         (cap <= 8) ? 7 : 63);
            no_gaps = 1'b0;
            settle();
        end

        if (errors == 0)
            $display("lru_frame_replacer: match");
        else
            $display("lru_frame_replacer: mismatch");
        $finish;
    end

endmodule
